@@ rtl/core/fltpm_pkg.sv @@
// ----------------------------------------------------------------------------
// Four-level page table mapper package
// Shared constants and codes for the page table mapper.
// ----------------------------------------------------------------------------
package fltpm_pkg;

    localparam int unsigned PoolPagesDef = 16;
    localparam int unsigned EntW         = 64;
    localparam int unsigned FrameW       = 40;
    localparam int unsigned IdxW         = 9;

    localparam logic [63:0] EntP    = 64'h1;
    localparam logic [63:0] EntWr   = 64'h2;
    localparam logic [63:0] EntU    = 64'h4;
    localparam logic [63:0] EntWt   = 64'h8;
    localparam logic [63:0] EntCd   = 64'h10;
    localparam logic [63:0] EntHuge = 64'h80;
    localparam logic [63:0] AddrBits = 64'h000F_FFFF_FFFF_F000;

    // Operation codes
    localparam logic [1:0] FnMap4k  = 2'd0;
    localparam logic [1:0] FnUnmap  = 2'd1;
    localparam logic [1:0] FnMmio   = 2'd2;
    localparam logic [1:0] FnMarkU  = 2'd3;

    // Status codes
    localparam logic [1:0] StDone    = 2'd0;
    localparam logic [1:0] StNoMap   = 2'd1;
    localparam logic [1:0] StHuge    = 2'd2;
    localparam logic [1:0] StNoPool  = 2'd3;

endpackage

@@ rtl/core/fltpm_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read a cycle, registered read data.
// ----------------------------------------------------------------------------
module fltpm_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ rtl/core/four_level_page_table_mapper.sv @@
// ----------------------------------------------------------------------------
// Four-level page table mapper
// Walks and edits x86-64 four-level page tables held in a table page pool.
// ----------------------------------------------------------------------------
// Each item walks the levels in order. Each upper level steps through read, wait,
// evaluate and follow; the last level steps through read, wait and evaluate, and
// the response is then presented. Each page taken from the pool is cleared before
// the walk goes on. Only one item is handled at a time; the next request beat can
// be taken in the cycle after the response beat. Reset: synchronous, active low; the
// root page is cleared before the first item. Configuration is always taken outside reset.
module four_level_page_table_mapper #(
    parameter int unsigned POOL_PAGES = fltpm_pkg::PoolPagesDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [39:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // func[1:0], virt[49:2], phys[101:50], flags[165:102], zero fill
    input  logic [167:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // status[1:0], entry_written[65:2], zero fill
    output logic [71:0]   m_axis_tdata
);
    import fltpm_pkg::*;

    localparam int unsigned PgW = (POOL_PAGES > 2) ? $clog2(POOL_PAGES) : 1;
    localparam int unsigned CntW = $clog2(POOL_PAGES + 1);
    localparam int unsigned AW = PgW + IdxW;
    localparam int unsigned Depth = POOL_PAGES * 512;

    typedef enum logic [7:0] {
        S_CLR  = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_RD   = 8'b0000_0100,
        S_WAIT = 8'b0000_1000,
        S_EVAL = 8'b0001_0000,
        S_ZERO = 8'b0010_0000,
        S_LEAF = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [39:0]     r_base;
    logic [1:0]      r_func;
    logic [47:0]     r_virt;
    logic [51:0]     r_phys;
    logic [63:0]     r_flags;
    logic [1:0]      r_lvl, n_lvl;
    logic [PgW-1:0]  r_tbl, n_tbl;
    logic [CntW-1:0] r_next, n_next;
    logic [IdxW-1:0] r_cnt, n_cnt;
    logic [PgW-1:0]  r_clr_pg, n_clr_pg;
    logic [1:0]      r_status, n_status;
    logic [63:0]     r_ent, n_ent;
    logic [63:0]     r_pend, n_pend;
    logic [AW-1:0]   r_slot, n_slot;

    logic            we;
    logic [AW-1:0]   addr;
    logic [63:0]     wdata, rdata;

    fltpm_ram #(.WIDTH(EntW), .DEPTH(Depth)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    // Index of the current level from the working address
    logic [47:0]     waddr;
    logic [IdxW-1:0] lidx;
    logic [63:0]     inter, nent;
    logic [39:0]     frame, off;
    logic            in_pool, alloc_ok;
    always_comb begin
        waddr = (r_func == FnMmio) ? {r_phys[47:21], 21'd0} : r_virt;
        case (r_lvl)
            2'd0:    lidx = waddr[47:39];
            2'd1:    lidx = waddr[38:30];
            2'd2:    lidx = waddr[29:21];
            default: lidx = waddr[20:12];
        endcase
        inter = (r_func == FnMap4k) ? (EntP | EntWr | (r_flags & EntU)) : (EntP | EntWr);
        frame = r_pend[51:12];
        off = frame - r_base;
        in_pool = (off < 40'(POOL_PAGES));
        alloc_ok = (r_next < CntW'(POOL_PAGES));
        nent = {12'd0, (r_base + 40'(r_next)), 12'd0} | inter;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata = {6'd0, r_ent, r_status};
    assign o_cfg_ready = 1'b1;

    // Sequencer over the shared memory port
    always_comb begin
        n_state = r_state; n_lvl = r_lvl; n_tbl = r_tbl; n_next = r_next;
        n_cnt = r_cnt; n_clr_pg = r_clr_pg;
        n_status = r_status; n_ent = r_ent; n_pend = r_pend; n_slot = r_slot;
        we = 1'b0; addr = {r_tbl, lidx}; wdata = 64'd0;
        case (r_state)
            S_CLR: begin
                we = 1'b1; addr = {r_clr_pg, r_cnt};
                n_cnt = r_cnt + 1'b1;
                if (&r_cnt) n_state = S_IDLE;
            end
            S_IDLE: begin
                n_lvl = 2'd0; n_tbl = '0; n_status = StDone; n_ent = 64'd0;
                if (s_axis_tvalid) n_state = S_RD;
            end
            S_RD: begin
                n_slot = {r_tbl, lidx};
                n_state = S_WAIT;
            end
            S_WAIT: begin
                addr = r_slot;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                addr = r_slot;
                n_pend = rdata;
                n_state = S_LEAF;
                if (r_lvl == 2'd3) begin
                    // 4K leaf write
                    we = 1'b1;
                    wdata = (r_func == FnMap4k) ?
                        (({12'd0, r_phys} & AddrBits) | r_flags | EntP) : 64'd0;
                    n_ent = wdata; n_state = S_OUT;
                end else if (r_lvl == 2'd2 && r_func != FnMap4k && r_func != FnUnmap) begin
                    // Huge page level
                    if (r_func == FnMmio) begin
                        we = 1'b1;
                        wdata = {12'd0, r_phys[51:21], 21'd0} | EntP | EntWr | EntHuge
                              | EntCd | EntWt;
                        n_ent = wdata; n_state = S_OUT;
                    end else if (rdata[7]) begin
                        we = 1'b1; wdata = rdata | EntU; n_ent = wdata; n_state = S_OUT;
                    end else begin
                        n_status = StNoMap; n_state = S_OUT;
                    end
                end else if (r_lvl == 2'd2 && rdata[7]) begin
                    n_status = StHuge; n_state = S_OUT;
                end else if (!rdata[0]) begin
                    if (r_func == FnUnmap || r_func == FnMarkU) begin
                        n_status = StNoMap; n_state = S_OUT;
                    end else if (!alloc_ok) begin
                        n_status = StNoPool; n_state = S_OUT;
                    end else begin
                        we = 1'b1; wdata = nent; n_pend = nent;
                        n_clr_pg = PgW'(r_next); n_next = r_next + 1'b1;
                        n_cnt = '0; n_state = S_ZERO;
                    end
                end else if (r_func == FnMap4k) begin
                    we = 1'b1; wdata = rdata | inter; n_pend = wdata;
                end
            end
            S_ZERO: begin
                // Clear the page just taken from the pool
                we = 1'b1; addr = {r_clr_pg, r_cnt};
                n_cnt = r_cnt + 1'b1;
                if (&r_cnt) n_state = S_LEAF;
            end
            S_LEAF: begin
                // Follow the pointer to the next level, or end with no mapping if it leaves the pool
                if (!in_pool) begin
                    n_status = StNoMap; n_state = S_OUT;
                end else begin
                    n_tbl = off[PgW-1:0]; n_lvl = r_lvl + 1'b1; n_state = S_RD;
                end
            end
            S_OUT: begin
                if (r_status != StDone) n_ent = 64'd0;
                if (m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_next <= CntW'(1); r_cnt <= '0; r_clr_pg <= '0;
            r_base <= 40'd0; r_status <= StDone; r_ent <= 64'd0;
        end else begin
            r_state <= n_state; r_next <= n_next; r_cnt <= n_cnt;
            r_clr_pg <= n_clr_pg; r_status <= n_status;
            r_ent <= (r_state == S_OUT && r_status != StDone) ? 64'd0 : n_ent;
            if (i_cfg_valid) r_base <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl <= n_lvl; r_tbl <= n_tbl;
        r_pend <= n_pend; r_slot <= n_slot;
        if (s_axis_tvalid && s_axis_tready) begin
            r_func <= s_axis_tdata[1:0];
            r_virt <= s_axis_tdata[49:2];
            r_phys <= s_axis_tdata[101:50];
            r_flags <= s_axis_tdata[165:102];
        end
    end
endmodule
